// ----- sv/mtea_pkg.sv -----
// Package for the multi-tap echo average block.
// Holds field widths, reset values, register indexes and the state type.
// Depends on nothing; the interfaces, the block, its checker and the testbench use it.
package mtea_pkg;

  // Default sizing of the sample history and of the echo tap count.
  localparam int unsigned HISTORY_DEPTH = 16384;
  localparam int unsigned MAX_ECHOES    = 4;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned SPACING_W = 12;
  localparam int unsigned ECHO_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = SPACING_W;

  // Offset of the unsigned audio format: this code is silence.
  localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 8'd128;

  // An average of signed 8-bit terms always has a magnitude of at most 128,
  // so eight quotient bits cover it.  The divider retires two bits a cycle.
  localparam int unsigned QUO_W     = 8;
  localparam int unsigned DIV_STEPS = QUO_W / 2;

  // Register reset values.
  localparam logic [SPACING_W-1:0] TAP_SPACING_RST = 12'd1000;
  localparam logic [ECHO_W-1:0]    ECHO_COUNT_RST  = 3'd3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_SPACING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_ABS,
    ST_DIV,
    ST_DONE
  } mtea_state_e;

endpackage

// ----- sv/mtea_if.sv -----
// Handshake interfaces for the sample input and output channels.
// Depends on mtea_pkg for the sample width.
interface mtea_in_if;
  logic                          valid;
  logic                          ready;
  logic [mtea_pkg::SAMPLE_W-1:0] sample_in;
  logic                          clip_start;

  modport source (output valid, output sample_in, output clip_start, input ready);
  modport sink (input valid, input sample_in, input clip_start, output ready);
  modport monitor (input valid, input sample_in, input clip_start, input ready);
endinterface

interface mtea_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtea_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
  modport monitor (input valid, input sample_out, input ready);
endinterface

// ----- sv/mtea_ram.sv -----
// Generic single-clock RAM: one write port and one read port, registered read.
// No dependencies.
module mtea_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/multi_tap_echo_average.sv -----
// Multi-tap echo average: one result per sample, sequential sequencer over a history RAM.
// It takes no new sample until the last result has moved into the output register.
// The sequencer reads the history RAM at most once per tap, then runs a radix-4 divider.
// Async active-low reset clears pointer, clip count, FSM, config regs, flags; not the RAM.
// Depends on mtea_pkg, mtea_if (mtea_in_if, mtea_out_if) and mtea_ram.
module multi_tap_echo_average #(
  parameter int unsigned HISTORY_DEPTH = mtea_pkg::HISTORY_DEPTH,
  parameter int unsigned MAX_ECHOES    = mtea_pkg::MAX_ECHOES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mtea_in_if.sink                           smp_in_i,
  mtea_out_if.source                        smp_out_o,
  input  logic                              cfg_we_i,
  input  logic [mtea_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtea_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Address width of the history; also holds the clip sample count, which
  // saturates at HISTORY_DEPTH - 1.
  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  // Tap index, tap count and term count all stay within 0..MAX_ECHOES + 1.
  localparam int unsigned TW = $clog2(MAX_ECHOES + 2);
  // Tap distance k * tap_spacing for k up to MAX_ECHOES.
  localparam int unsigned DW = mtea_pkg::SPACING_W + $clog2(MAX_ECHOES + 1);
  // Width for the wrap-around address arithmetic.
  localparam int unsigned XW = ((AW > DW) ? AW : DW) + 1;
  // Signed sum of up to MAX_ECHOES + 1 terms in -128..127.
  localparam int unsigned SUM_W = $clog2((MAX_ECHOES + 1) * 128 + 1) + 1;
  // Divider compare width: a divisor shifted up by as much as QUO_W - 1.
  localparam int unsigned CW = SUM_W + TW + 1;
  localparam int unsigned QB = $clog2(mtea_pkg::QUO_W);
  localparam int unsigned SW = (mtea_pkg::DIV_STEPS > 1) ? $clog2(mtea_pkg::DIV_STEPS) : 1;
  localparam int unsigned SMP = mtea_pkg::SAMPLE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Users must write only while the block is idle; not enforced.
  // ---------------------------------------------------------------------------
  logic [mtea_pkg::SPACING_W-1:0] tap_spacing_q;
  logic [mtea_pkg::ECHO_W-1:0]    echo_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_spacing_q <= mtea_pkg::TAP_SPACING_RST;
      echo_count_q  <= mtea_pkg::ECHO_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mtea_pkg::CFG_TAP_SPACING: tap_spacing_q <= cfg_data_i;
        mtea_pkg::CFG_ECHO_COUNT:  echo_count_q  <= cfg_data_i[mtea_pkg::ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers.
  // ---------------------------------------------------------------------------
  mtea_pkg::mtea_state_e state_q, state_d;

  logic [AW-1:0]     wp_q;        // next history slot to write
  logic [AW-1:0]     seen_q;      // clip samples before the next one, saturating
  logic [AW-1:0]     base_wp_q;   // slot of the sample in flight
  logic [AW-1:0]     work_seen_q; // clip samples before the sample in flight
  logic [SMP-1:0]    cur_q;       // offset-free sample in flight (two's complement)
  logic [TW-1:0]     taps_q;      // echo taps to visit for this item
  logic [TW-1:0]     k_q;         // tap being visited
  logic [DW-1:0]     dist_q;      // distance of tap k_q
  logic              rd_pend_q;   // a history read returns this cycle
  logic [SUM_W-1:0]  sum_q;
  logic [TW-1:0]     terms_q;
  logic              neg_q;
  logic [SUM_W-1:0]  rem_q;
  logic [mtea_pkg::QUO_W-1:0] quo_q;
  logic [SW-1:0]     step_q;
  logic              out_valid_q;
  logic [SMP-1:0]    sample_out_q;

  // ---------------------------------------------------------------------------
  // Combinational helpers.
  // ---------------------------------------------------------------------------
  logic              in_xfer;
  logic              out_free;
  logic [SMP-1:0]    cur_in;
  logic [AW-1:0]     seen_eff;
  logic [TW-1:0]     taps_eff;
  logic              tap_live;
  logic              dist_ok;
  logic              rd_issue;
  logic              zero_add;
  logic [XW-1:0]     base_x, dist_x, idx_x;
  logic [SMP-1:0]    hist_rdata;
  logic [SUM_W-1:0]  rd_term, cur_term, sum_d;
  logic [SUM_W-1:0]  mag;
  logic [QB-1:0]     bit_hi, bit_lo;
  logic [CW-1:0]     rem_x, dsh_hi, dsh_lo, rem_a, rem_b;
  logic              qb_hi, qb_lo;
  logic [SMP:0]      avg_s;
  logic [SMP-1:0]    result;

  assign in_xfer  = smp_in_i.valid & smp_in_i.ready;
  // The result register may be reloaded when empty or when its transfer
  // completes in this very cycle.
  assign out_free = !out_valid_q || smp_out_o.ready;

  // Removing the offset of 128 is a flip of the top bit.
  assign cur_in   = smp_in_i.sample_in - mtea_pkg::SAMPLE_OFFSET;
  // A clip start, and likewise the first sample after reset, sees no history.
  assign seen_eff = smp_in_i.clip_start ? '0 : seen_q;
  assign taps_eff = (32'(echo_count_q) > MAX_ECHOES) ? TW'(MAX_ECHOES) : TW'(echo_count_q);

  // Tap visit: a tap counts only if it lies inside the current clip. With a
  // spacing of zero every tap is the current sample itself and needs no read.
  assign tap_live = (state_q == mtea_pkg::ST_TAP) && (k_q <= taps_q);
  assign dist_ok  = 32'(dist_q) <= 32'(work_seen_q);
  assign zero_add = tap_live && (dist_q == '0);
  assign rd_issue = tap_live && (dist_q != '0) && dist_ok;

  // History slot of the tap, modulo the history depth. The distance never
  // exceeds the clip count, which stays below the depth.
  assign base_x = XW'(base_wp_q);
  assign dist_x = XW'(dist_q);
  assign idx_x  = (base_x >= dist_x) ? (base_x - dist_x) : (base_x + XW'(HISTORY_DEPTH) - dist_x);

  mtea_ram #(
    .WIDTH (SMP),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (wp_q),
    .wdata_i (cur_in),
    .re_i    (rd_issue),
    .raddr_i (idx_x[AW-1:0]),
    .rdata_o (hist_rdata)
  );

  // Accumulation: a read issued last cycle lands now, and a zero-distance tap
  // adds the current sample again. Both can be folded in one add.
  assign rd_term  = rd_pend_q ? {{(SUM_W-SMP){hist_rdata[SMP-1]}}, hist_rdata} : '0;
  assign cur_term = zero_add  ? {{(SUM_W-SMP){cur_q[SMP-1]}}, cur_q} : '0;
  assign sum_d    = sum_q + rd_term + cur_term;

  assign mag = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;

  // Restoring division, two quotient bits per cycle from the top. The
  // quotient is known to fit in QUO_W bits, so each shifted divisor compare
  // is exact.
  assign bit_hi = QB'(mtea_pkg::QUO_W - 1) - QB'({step_q, 1'b0});
  assign bit_lo = bit_hi - QB'(1);
  assign rem_x  = CW'(rem_q);
  assign dsh_hi = CW'(terms_q) << bit_hi;
  assign dsh_lo = CW'(terms_q) << bit_lo;
  assign qb_hi  = rem_x >= dsh_hi;
  assign rem_a  = qb_hi ? (rem_x - dsh_hi) : rem_x;
  assign qb_lo  = rem_a >= dsh_lo;
  assign rem_b  = qb_lo ? (rem_a - dsh_lo) : rem_a;

  // Truncation toward zero: divide magnitudes, then restore the sign. An
  // average always lies in -128..127, so adding the offset back cannot wrap.
  assign avg_s  = neg_q ? ((SMP+1)'(0) - (SMP+1)'(quo_q)) : (SMP+1)'(quo_q);
  assign result = SMP'(avg_s + (SMP+1)'(mtea_pkg::SAMPLE_OFFSET));

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes a sample, TAP walks the echo taps through the RAM,
  // ABS takes the magnitude of the sum, DIV runs the divider and DONE hands
  // the result to the output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtea_pkg::ST_IDLE: if (in_xfer) state_d = mtea_pkg::ST_TAP;
      mtea_pkg::ST_TAP:  if (k_q > taps_q) state_d = mtea_pkg::ST_ABS;
      mtea_pkg::ST_ABS:  state_d = mtea_pkg::ST_DIV;
      mtea_pkg::ST_DIV:  if (step_q == SW'(mtea_pkg::DIV_STEPS - 1)) state_d = mtea_pkg::ST_DONE;
      mtea_pkg::ST_DONE: if (out_free) state_d = mtea_pkg::ST_IDLE;
      default:           state_d = mtea_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs. The input is open in IDLE even while an earlier
  // result still waits in the output register.
  always_comb begin
    smp_in_i.ready       = (state_q == mtea_pkg::ST_IDLE);
    smp_out_o.valid      = out_valid_q;
    smp_out_o.sample_out = sample_out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtea_pkg::ST_IDLE;
      wp_q        <= '0;
      seen_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_issue;
      if (in_xfer) begin
        wp_q   <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        seen_q <= (seen_eff == AW'(HISTORY_DEPTH - 1)) ? seen_eff : seen_eff + AW'(1);
      end
      if (state_q == mtea_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (smp_out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mtea_pkg::ST_IDLE: begin
        if (in_xfer) begin
          base_wp_q   <= wp_q;
          work_seen_q <= seen_eff;
          cur_q       <= cur_in;
          taps_q      <= taps_eff;
          k_q         <= TW'(1);
          dist_q      <= DW'(tap_spacing_q);
          sum_q       <= {{(SUM_W-SMP){cur_in[SMP-1]}}, cur_in};
          terms_q     <= TW'(1);
        end
      end
      mtea_pkg::ST_TAP: begin
        sum_q <= sum_d;
        if (rd_issue || zero_add) begin
          terms_q <= terms_q + TW'(1);
        end
        if (tap_live) begin
          k_q    <= k_q + TW'(1);
          dist_q <= dist_q + DW'(tap_spacing_q);
        end
      end
      mtea_pkg::ST_ABS: begin
        neg_q  <= sum_q[SUM_W-1];
        rem_q  <= mag;
        quo_q  <= '0;
        step_q <= '0;
      end
      mtea_pkg::ST_DIV: begin
        rem_q  <= SUM_W'(rem_b);
        quo_q  <= {quo_q[mtea_pkg::QUO_W-3:0], qb_hi, qb_lo};
        step_q <= step_q + SW'(1);
      end
      mtea_pkg::ST_DONE: begin
        if (out_free) begin
          sample_out_q <= result;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/mtea_checker.sv -----
// Port-level checker for multi_tap_echo_average, bound to the top level.
// Depends on mtea_pkg for the sample width.
module mtea_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [mtea_pkg::SAMPLE_W-1:0] sample_out_i
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] open_q;

  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;

  // Samples taken whose result has not yet been transferred out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_xfer && !out_xfer && open_q != 2'd3) begin
      open_q <= open_q + 2'd1;
    end else if (out_xfer && !in_xfer && open_q != 2'd0) begin
      open_q <= open_q - 2'd1;
    end
  end

  // A result is never delivered without a sample behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> open_q != 2'd0)
    else $error("result transfer without an open sample");

  // At most one finished result waits while the next sample is taken.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> open_q <= 2'd1)
    else $error("sample taken with too many results pending");

  // The block works on one sample at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_out_i))
    else $error("stalled result changed");

endmodule

bind multi_tap_echo_average mtea_checker u_mtea_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (smp_in_i.valid),
  .in_ready_i   (smp_in_i.ready),
  .out_valid_i  (smp_out_o.valid),
  .out_ready_i  (smp_out_o.ready),
  .sample_out_i (smp_out_o.sample_out)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the multi-tap echo average block.
// Depends on mtea_pkg, the mtea_in_if / mtea_out_if interfaces and the block's RTL.
// It runs a stimulus table and then random clips, checking each result with a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned HIST_SLOTS = mtea_pkg::HISTORY_DEPTH;
  localparam int unsigned PTR_W      = $clog2(mtea_pkg::HISTORY_DEPTH);
  localparam int unsigned SAMPLE_W   = mtea_pkg::SAMPLE_W;
  localparam int unsigned SPACING_W  = mtea_pkg::SPACING_W;
  localparam int unsigned ECHO_W     = mtea_pkg::ECHO_W;
  localparam int unsigned CFG_IDX_W  = mtea_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = mtea_pkg::CFG_DATA_W;
  localparam int unsigned MAX_ECHOES = mtea_pkg::MAX_ECHOES;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_e;

  // One row of the directed table. A sample row may carry a hand-typed result.
  // A write row sets one register between transfers.
  typedef struct {
    row_kind_e             kind;
    logic [SAMPLE_W-1:0]   smp;
    logic                  clip;
    logic                  known;
    logic [SAMPLE_W-1:0]   want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } step_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  // When this is set, neither side idles. That gives long back-to-back stretches.
  logic                  steady_flow;

  mtea_in_if  smp_in ();
  mtea_out_if smp_out ();

  multi_tap_echo_average dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .smp_in_i   (smp_in),
    .smp_out_o  (smp_out),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: its own copy of the sample history, the write pointer, the count of
  // samples in the current clip, and the two registers as last written.
  logic signed [SAMPLE_W-1:0] hist_mem [HIST_SLOTS];
  logic [PTR_W-1:0]           wr_ptr;
  logic [PTR_W-1:0]           clip_len;
  logic [SPACING_W-1:0]       spacing_q;
  logic [ECHO_W-1:0]          echoes_q;

  // Averages that are still owed by the block, oldest first.
  logic [SAMPLE_W-1:0]        avg_due_q [$];
  logic [SAMPLE_W-1:0]        avg_head;
  int                         mismatch_cnt;

  // The directed table. After reset, the first sample starts a clip even without the flag.
  // A zero tap spacing makes every tap reread the current sample. An echo count above
  // the tap limit acts as the limit. Taps that reach back past the clip start are skipped.
  // With the echo count at zero, the sample passes straight through. The averages of
  // +1/0 and -1/0 must both truncate toward zero, so both give silence.
  step_row_t dir_rows [26] = '{
    '{ROW_SAMPLE, 8'd0,   1'b0, 1'b1, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd255, 1'b0, 1'b1, 8'd255, mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd128, 1'b1, 1'b1, 8'd128, mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_WRITE,  8'd0,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_WRITE,  8'd0,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_ECHO_COUNT,  12'd4},
    '{ROW_SAMPLE, 8'd255, 1'b0, 1'b1, 8'd255, mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd0,   1'b0, 1'b1, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd1,   1'b1, 1'b1, 8'd1,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_WRITE,  8'd0,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd1},
    '{ROW_WRITE,  8'd0,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_ECHO_COUNT,  12'd7},
    '{ROW_SAMPLE, 8'd200, 1'b1, 1'b1, 8'd200, mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd10,  1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd250, 1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd3,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd77,  1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd131, 1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_WRITE,  8'd0,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_ECHO_COUNT,  12'd1},
    '{ROW_SAMPLE, 8'd129, 1'b1, 1'b1, 8'd129, mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd128, 1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd127, 1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_WRITE,  8'd0,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_ECHO_COUNT,  12'd0},
    '{ROW_SAMPLE, 8'd37,  1'b0, 1'b1, 8'd37,  mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_WRITE,  8'd0,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd4095},
    '{ROW_WRITE,  8'd0,   1'b0, 1'b0, 8'd0,   mtea_pkg::CFG_ECHO_COUNT,  12'd4},
    '{ROW_SAMPLE, 8'd255, 1'b1, 1'b1, 8'd255, mtea_pkg::CFG_TAP_SPACING, 12'd0},
    '{ROW_SAMPLE, 8'd0,   1'b0, 1'b1, 8'd0,   mtea_pkg::CFG_TAP_SPACING, 12'd0}
  };

  // Predicts the averaged echo for one accepted sample and then advances the history,
  // as the block does. It removes the offset, adds every tap that lies inside the
  // current clip, and divides by the number of terms. The division of two ints in
  // SystemVerilog truncates toward zero, which is the rounding the block uses.
  function automatic logic [SAMPLE_W-1:0] echo_average(input logic [SAMPLE_W-1:0] smp,
                                                       input logic clip);
    int cur;
    int acc;
    int terms;
    int taps;
    int reach;
    int slot;
    cur   = int'(smp) - 128;
    taps  = (echoes_q > MAX_ECHOES) ? MAX_ECHOES : echoes_q;
    acc   = cur;
    terms = 1;
    if (clip) begin
      clip_len = '0;
    end
    for (int k = 1; k <= taps; k++) begin
      reach = k * int'(spacing_q);
      if (reach <= int'(clip_len)) begin
        if (reach == 0) begin
          acc += cur;
        end else begin
          slot = (int'(wr_ptr) + HIST_SLOTS - (reach % HIST_SLOTS)) % HIST_SLOTS;
          acc += hist_mem[slot];
        end
        terms++;
      end
    end
    acc = acc / terms;
    // An average of values in -128..127 stays in range, so this clamp is only a guard.
    if (acc < -128) begin
      acc = -128;
    end
    if (acc > 128) begin
      acc = 128;
    end
    echo_average = SAMPLE_W'(acc + 128);
    hist_mem[wr_ptr] = SAMPLE_W'(cur);
    wr_ptr = PTR_W'((int'(wr_ptr) + 1) % HIST_SLOTS);
    if (clip_len < PTR_W'(HIST_SLOTS - 1)) begin
      clip_len++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Offers one sample on the input channel and returns at the edge of its transfer.
  // The valid stays high afterward, so a following sample can go back to back. Each
  // call starts in its own time step, which is where the write enable gets lowered.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic clip,
                             input logic known, input logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] avg;
    cfg_we <= 1'b0;
    while (!steady_flow && $urandom_range(0, 99) < 18) begin
      smp_in.valid <= 1'b0;
      @(posedge clk);
    end
    smp_in.valid      <= 1'b1;
    smp_in.sample_in  <= smp;
    smp_in.clip_start <= clip;
    @(posedge clk);
    while (smp_in.ready !== 1'b1) begin
      @(posedge clk);
    end
    avg = echo_average(smp, clip);
    avg_due_q.push_back(known ? want : avg);
  endtask

  // Writes one register once the block has handed back every owed result. Since each
  // sample yields a result, an empty queue means the block is idle. The enable is left
  // high here. The next call of either task lowers or reuses it in its own time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    smp_in.valid <= 1'b0;
    while (avg_due_q.size() != 0) begin
      @(posedge clk);
    end
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == mtea_pkg::CFG_TAP_SPACING) begin
      spacing_q = val[SPACING_W-1:0];
    end else begin
      echoes_q = val[ECHO_W-1:0];
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The output side stalls at random, except during the steady stretches.
  always @(posedge clk) begin
    smp_out.ready <= steady_flow || ($urandom_range(0, 99) >= 18);
  end

  // Every result transfer is matched against the oldest owed average.
  always @(posedge clk) begin
    if (rst_n && smp_out.valid === 1'b1 && smp_out.ready === 1'b1) begin
      if (avg_due_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with none owed", smp_out.sample_out));
      end else begin
        avg_head = avg_due_q.pop_front();
        if (smp_out.sample_out !== avg_head) begin
          report_mismatch($sformatf("sample_out %0d, predicted %0d",
                                    smp_out.sample_out, avg_head));
        end
      end
    end
  end

  // Stimulus: the directed table, then a dozen short phases, then one long clip.
  initial begin
    logic [CFG_DATA_W-1:0] val;
    logic [SAMPLE_W-1:0]   smp;
    logic                  noisy;
    logic                  clip;
    rst_n             = 1'b0;
    smp_in.valid      = 1'b0;
    smp_in.sample_in  = '0;
    smp_in.clip_start = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = mtea_pkg::CFG_TAP_SPACING;
    cfg_data          = '0;
    steady_flow       = 1'b0;
    mismatch_cnt      = 0;
    wr_ptr            = '0;
    clip_len          = '0;
    spacing_q         = mtea_pkg::TAP_SPACING_RST;
    echoes_q          = mtea_pkg::ECHO_COUNT_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].clip, dir_rows[i].known, dir_rows[i].want);
      end
    end

    // Most phases are long clips with short tap spacings, so that all taps come into
    // play. Every fourth phase is noise, with clip starts arriving every few samples.
    // Phase four runs with no idling on either side.
    for (int ph = 0; ph < 12; ph++) begin
      val = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(13, 400))
                                        : CFG_DATA_W'($urandom_range(0, 12));
      write_reg(mtea_pkg::CFG_TAP_SPACING, val);
      // The bits above the echo count field are random; the block should ignore them.
      val = CFG_DATA_W'($urandom);
      val[ECHO_W-1:0] = ECHO_W'($urandom_range(0, 7));
      write_reg(mtea_pkg::CFG_ECHO_COUNT, val);
      steady_flow <= (ph == 4);
      noisy = (ph % 4 == 3);
      for (int n = 0; n < 60; n++) begin
        clip = (n == 0) || ($urandom_range(0, noisy ? 3 : 59) == 0);
        smp = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                          : SAMPLE_W'($urandom);
        send_sample(smp, clip, 1'b0, '0);
      end
    end

    // One clip long enough for all four taps of a wider spacing to reach back inside it.
    // Its first half runs with no idling.
    write_reg(mtea_pkg::CFG_TAP_SPACING, CFG_DATA_W'(50));
    val = CFG_DATA_W'($urandom);
    val[ECHO_W-1:0] = ECHO_W'(MAX_ECHOES);
    write_reg(mtea_pkg::CFG_ECHO_COUNT, val);
    for (int n = 0; n < 260; n++) begin
      steady_flow <= (n < 130);
      send_sample(SAMPLE_W'($urandom), n == 0, 1'b0, '0);
    end

    smp_in.valid <= 1'b0;
    steady_flow  <= 1'b0;
    while (avg_due_q.size() != 0) begin
      @(posedge clk);
    end
    // Keep waiting, to catch a stray extra result.
    repeat (24) @(posedge clk);
    if (avg_due_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", avg_due_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this time.
  initial begin
    #600000;
    $display("timeout: %0d results still owed", avg_due_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
